@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ src/emi_pkg.sv @@
`timescale 1ns / 1ps

package emi_pkg;

  localparam int PROB_FRAC_BITS   = 16;
  localparam int RESULT_FRAC_BITS = 16;
  localparam int LOG_TABLE_BITS   = 6;

  localparam int LOG_FRAC  = 20;
  localparam int MANT_BITS = 30;

  localparam int IN_W      = 17;
  localparam int MEAS_W    = 22;
  localparam int ACC_W     = 40;
  localparam int E_W       = $clog2(IN_W);
  localparam int NORM_W    = MANT_BITS + 1;
  localparam int TAB_SIZE  = (1 << LOG_TABLE_BITS) + 1;
  localparam int TAB_IDX_W = LOG_TABLE_BITS + 1;
  localparam int ROM_W     = LOG_FRAC + 1;
  localparam int REM_W     = MANT_BITS - LOG_TABLE_BITS;
  localparam int LOG_W     = LOG_FRAC + 6;
  localparam int L_W       = LOG_W + 2;
  localparam int PROD_W    = IN_W + 1 + L_W;
  localparam int SHIFT     = PROB_FRAC_BITS + LOG_FRAC - RESULT_FRAC_BITS;
  localparam int TERM_W    = PROD_W - SHIFT + 1;

  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  localparam logic [ACC_W-1:0] MEAS_MAX_ACC = ACC_W'((64'd1 << MEAS_W) - 64'd1);
  localparam logic [TERM_W-1:0] MEAS_MAX_TERM = TERM_W'((64'd1 << MEAS_W) - 64'd1);
  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef logic [ROM_W-1:0] rom_t [TAB_SIZE];

  typedef struct packed {
    logic                     add_en;
    logic                     term_sat;
    logic                     last;
    logic signed [TERM_W-1:0] term;
  } emi_term_t;

  // log2(1 + k/2^LOG_TABLE_BITS) by repeated squaring, truncated each step.
  function automatic rom_t build_log_rom();
    rom_t             rom;
    logic [63:0]      y;
    logic [ROM_W-1:0] r;
    for (int k = 0; k < TAB_SIZE; k++) begin
      if (k == TAB_SIZE - 1) begin
        rom[k] = ROM_W'(1) << LOG_FRAC;
      end else begin
        y = (64'd1 << MANT_BITS) + (64'(k) << (MANT_BITS - LOG_TABLE_BITS));
        r = '0;
        for (int i = 0; i < LOG_FRAC; i++) begin
          y = (y * y) >> MANT_BITS;
          r = r << 1;
          if (y >= (64'd2 << MANT_BITS)) begin
            y = y >> 1;
            r[0] = 1'b1;
          end
        end
        rom[k] = r;
      end
    end
    return rom;
  endfunction

  localparam rom_t LOG_ROM = build_log_rom();

endpackage

@@ src/emi_fifo.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module emi_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  emi_pkg::emi_term_t wdata,
  input  logic               pop,
  output emi_pkg::emi_term_t rdata,
  output logic               empty
);

  emi_pkg::emi_term_t                mem [emi_pkg::QDEPTH];
  logic [emi_pkg::QPTR_W-1:0]        wr_ptr;
  logic [emi_pkg::QPTR_W-1:0]        rd_ptr;
  logic [emi_pkg::CNT_W-1:0]         count;

  assign rdata = mem[rd_ptr];
  assign empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= emi_pkg::CNT_W'(count + emi_pkg::CNT_W'(push) - emi_pkg::CNT_W'(pop));
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  `ASSERT_IMP(a_no_overflow, clk, rst, push && !pop, count < emi_pkg::CNT_W'(emi_pkg::QDEPTH))
  `ASSERT_IMP(a_no_underflow, clk, rst, pop, !empty)

endmodule

@@ src/emi_front.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module emi_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic [emi_pkg::IN_W-1:0] prob,
  input  logic [emi_pkg::IN_W-1:0] marg_a,
  input  logic [emi_pkg::IN_W-1:0] marg_b,
  input  logic                     last,
  input  logic                     mode,
  input  logic                     q_pop,
  output logic                     q_push,
  output emi_pkg::emi_term_t       q_data
);

  typedef struct packed {
    logic valid;
    logic mode;
    logic last;
    logic p_nz;
    logic marg_zero;
  } ctl_t;

  typedef struct packed {
    logic [emi_pkg::E_W-1:0]   e;
    logic [emi_pkg::ROM_W-1:0] lo;
    logic [emi_pkg::ROM_W-1:0] diff;
    logic [emi_pkg::REM_W-1:0] rem;
  } lane_t;

  function automatic lane_t log_lookup(input logic [emi_pkg::IN_W-1:0] x);
    logic [emi_pkg::E_W-1:0]       e;
    logic [emi_pkg::NORM_W-1:0]    norm;
    logic [emi_pkg::MANT_BITS-1:0] frac;
    logic [emi_pkg::TAB_IDX_W-1:0] idx;
    lane_t                         res;
    e = '0;
    for (int j = 1; j < emi_pkg::IN_W; j++) begin
      if (x[j]) begin
        e = emi_pkg::E_W'(j);
      end
    end
    norm = emi_pkg::NORM_W'(x) << (emi_pkg::MANT_BITS - int'(e));
    frac = norm[emi_pkg::MANT_BITS-1:0];
    idx  = {1'b0, frac[emi_pkg::MANT_BITS-1 -: emi_pkg::LOG_TABLE_BITS]};
    res.e    = e;
    res.lo   = emi_pkg::LOG_ROM[idx];
    res.diff = emi_pkg::LOG_ROM[idx + 1'b1] - emi_pkg::LOG_ROM[idx];
    res.rem  = frac[emi_pkg::REM_W-1:0];
    return res;
  endfunction

  function automatic logic signed [emi_pkg::LOG_W-1:0] log_value(input lane_t l);
    logic [emi_pkg::ROM_W+emi_pkg::REM_W-1:0] pr;
    logic [emi_pkg::ROM_W-1:0]                interp;
    logic signed [emi_pkg::LOG_W-1:0]         ex;
    pr     = l.diff * l.rem;
    interp = l.lo + pr[emi_pkg::REM_W +: emi_pkg::ROM_W];
    ex     = $signed(emi_pkg::LOG_W'(l.e)) - $signed(emi_pkg::LOG_W'(emi_pkg::PROB_FRAC_BITS));
    return (ex <<< emi_pkg::LOG_FRAC) + $signed(emi_pkg::LOG_W'(interp));
  endfunction

  localparam logic [emi_pkg::PROD_W-1:0] ROUND_HALF =
    emi_pkg::PROD_W'(1) << (emi_pkg::SHIFT - 1);

  logic [emi_pkg::CNT_W-1:0] inflight;
  logic                      accept;

  ctl_t ctl0, ctl1, ctl2, ctl3, ctl4, ctl5;

  logic [emi_pkg::IN_W-1:0] p0, a0, b0, p1, p2, p3;
  lane_t                    lane_p, lane_a, lane_b;
  logic signed [emi_pkg::LOG_W-1:0]  lp, la, lb;
  logic signed [emi_pkg::L_W-1:0]    lsum, lsum_next;
  logic signed [emi_pkg::PROD_W-1:0] prod, prod_next;
  logic [emi_pkg::PROD_W-1:0]        mag, mag_r;
  logic signed [emi_pkg::TERM_W-1:0] term, term_next;

  assign full   = (inflight == emi_pkg::CNT_W'(emi_pkg::QDEPTH));
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
      ctl0     <= '0;
      ctl1     <= '0;
      ctl2     <= '0;
      ctl3     <= '0;
      ctl4     <= '0;
      ctl5     <= '0;
    end else begin
      inflight <= emi_pkg::CNT_W'(inflight + emi_pkg::CNT_W'(accept) - emi_pkg::CNT_W'(q_pop));
      ctl0.valid     <= accept;
      ctl0.mode      <= mode;
      ctl0.last      <= last;
      ctl0.p_nz      <= (prob != '0);
      ctl0.marg_zero <= mode && (prob != '0) && ((marg_a == '0) || (marg_b == '0));
      ctl1 <= ctl0;
      ctl2 <= ctl1;
      ctl3 <= ctl2;
      ctl4 <= ctl3;
      ctl5 <= ctl4;
    end
  end

  always_comb begin
    if (ctl2.mode) begin
      lsum_next = emi_pkg::L_W'(lp) - emi_pkg::L_W'(la) - emi_pkg::L_W'(lb);
    end else begin
      lsum_next = emi_pkg::L_W'(lp);
    end
    prod_next = $signed({1'b0, p3}) * lsum;
    mag       = prod[emi_pkg::PROD_W-1] ? emi_pkg::PROD_W'(-prod) : emi_pkg::PROD_W'(prod);
    mag_r     = (mag + ROUND_HALF) >> emi_pkg::SHIFT;
    // entropy mode negates the term
    if (prod[emi_pkg::PROD_W-1] ^ !ctl4.mode) begin
      term_next = -$signed(emi_pkg::TERM_W'(mag_r));
    end else begin
      term_next = $signed(emi_pkg::TERM_W'(mag_r));
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p0 <= prob;
      a0 <= marg_a;
      b0 <= marg_b;
    end
    p1     <= p0;
    lane_p <= log_lookup(p0);
    lane_a <= log_lookup(a0);
    lane_b <= log_lookup(b0);
    p2     <= p1;
    lp     <= log_value(lane_p);
    la     <= log_value(lane_a);
    lb     <= log_value(lane_b);
    p3     <= p2;
    lsum   <= lsum_next;
    prod   <= prod_next;
    term   <= term_next;
  end

  assign q_push          = ctl5.valid;
  assign q_data.add_en   = ctl5.p_nz;
  assign q_data.term_sat = ctl5.marg_zero;
  assign q_data.last     = ctl5.last;
  assign q_data.term     = ctl5.marg_zero ? $signed(emi_pkg::MEAS_MAX_TERM) : term;

  `ASSERT_IMP(a_credit_bound, clk, rst, 1'b1, inflight <= emi_pkg::CNT_W'(emi_pkg::QDEPTH))

endmodule

@@ src/emi_back.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module emi_back (
  input  logic                       clk,
  input  logic                       rst,
  input  emi_pkg::emi_term_t         entry,
  input  logic                       q_empty,
  output logic                       q_pop,
  input  logic                       pop,
  output logic                       empty,
  output logic [emi_pkg::MEAS_W-1:0] measure,
  output logic                       saturated
);

  logic [emi_pkg::ACC_W-1:0] acc, acc_next;
  logic                      sat_flag, sat_next;
  logic                      out_valid;
  logic [emi_pkg::ACC_W:0]   sum;
  logic                      ovf;
  logic [emi_pkg::MEAS_W-1:0] meas_next;
  logic                      msat_next;

  assign q_pop = !q_empty && (!entry.last || !out_valid || pop);
  assign empty = !out_valid;

  always_comb begin
    sum = {acc[emi_pkg::ACC_W-1], acc} +
          {{(emi_pkg::ACC_W+1-emi_pkg::TERM_W){entry.term[emi_pkg::TERM_W-1]}}, entry.term};
    ovf = (sum[emi_pkg::ACC_W] != sum[emi_pkg::ACC_W-1]);
    acc_next = acc;
    sat_next = sat_flag;
    if (entry.add_en) begin
      if (ovf) begin
        acc_next = sum[emi_pkg::ACC_W] ? emi_pkg::ACC_MIN : emi_pkg::ACC_MAX;
      end else begin
        acc_next = sum[emi_pkg::ACC_W-1:0];
      end
      sat_next = sat_flag | entry.term_sat | ovf;
    end
    msat_next = sat_next;
    if (acc_next[emi_pkg::ACC_W-1]) begin
      meas_next = '0;
    end else if (acc_next > emi_pkg::MEAS_MAX_ACC) begin
      meas_next = emi_pkg::MEAS_MAX_ACC[emi_pkg::MEAS_W-1:0];
      msat_next = 1'b1;
    end else begin
      meas_next = acc_next[emi_pkg::MEAS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      sat_flag  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        if (entry.last) begin
          acc       <= '0;
          sat_flag  <= 1'b0;
          out_valid <= 1'b1;
        end else begin
          acc      <= acc_next;
          sat_flag <= sat_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && entry.last) begin
      measure   <= meas_next;
      saturated <= msat_next;
    end
  end

  `ASSERT_NEXT(a_clear_on_last, clk, rst, q_pop && entry.last, acc == '0 && !sat_flag)
  `ASSERT_IMP(a_no_overwrite, clk, rst, q_pop && entry.last && out_valid, pop)

endmodule

@@ src/entropy_mutual_info_accumulator.sv @@
`timescale 1ns / 1ps

// Base-2 entropy / mutual information accumulator. Push one Q1.16 term per
// cycle while full is low; measure_mode (cfg_we/cfg_wdata) picks entropy (0)
// or mutual information (1). The item with last set closes the distribution:
// its result (Q6.16, clamped at zero and at the top code, plus a sticky
// saturated bit) reaches the result side through the front and the term
// queue, and the sum clears. Sustained rate is one item per cycle while full
// is low: a six-stage front (input register, normalize and table lookup,
// interpolate, combine logs, multiply, round) feeds an eight-entry term
// queue, and full is a credit count over the front stages and that queue.
// The back end closes a single 40-bit saturating add per cycle and holds
// one finished result; when that result is not popped, the back end stalls
// only on the next last term and the queue absorbs the rest until full rises.
module entropy_mutual_info_accumulator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_wdata,
  input  logic                       push,
  output logic                       full,
  input  logic [emi_pkg::IN_W-1:0]   prob,
  input  logic [emi_pkg::IN_W-1:0]   marg_a,
  input  logic [emi_pkg::IN_W-1:0]   marg_b,
  input  logic                       last,
  output logic                       empty,
  input  logic                       pop,
  output logic [emi_pkg::MEAS_W-1:0] measure,
  output logic                       saturated
);

  logic               measure_mode;
  logic               q_push;
  logic               q_pop;
  logic               q_empty;
  emi_pkg::emi_term_t q_wdata;
  emi_pkg::emi_term_t q_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      measure_mode <= 1'b0;
    end else if (cfg_we) begin
      measure_mode <= cfg_wdata;
    end
  end

  emi_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .prob   (prob),
    .marg_a (marg_a),
    .marg_b (marg_b),
    .last   (last),
    .mode   (measure_mode),
    .q_pop  (q_pop),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  emi_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  emi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .entry     (q_rdata),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .pop       (pop),
    .empty     (empty),
    .measure   (measure),
    .saturated (saturated)
  );

endmodule
